### sv/hsi_pkg.sv
// ----------------------------------------------------------------------------
// Heater safety interlock package
// Shared types, codes and constants for the chamber-heater interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package hsi_pkg;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned TEMP_W = 16;

  localparam logic [6:0] FAN_FULL    = 7'd100;
  localparam logic [6:0] FAN_STOPPED = 7'd0;
  localparam logic [2:0] SENSORS_ALL = 3'b111;

  // Register index, taken from paddr bit 2.
  localparam logic REG_TARGET_MIN = 1'b0;
  localparam logic REG_TARGET_MAX = 1'b1;

  localparam logic signed [TEMP_W-1:0] TARGET_MIN_RST = 16'sd0;
  localparam logic signed [TEMP_W-1:0] TARGET_MAX_RST = 16'sd1280;

  // Bit positions in condition_flags.
  localparam int unsigned FLG_COMMISSIONED = 0;
  localparam int unsigned FLG_OVERTEMP     = 1;
  localparam int unsigned FLG_COOLDOWN     = 2;
  localparam int unsigned FLG_FAULT_THERM  = 3;
  localparam int unsigned FLG_ONLINE       = 4;
  localparam int unsigned FLG_PRINTING     = 5;
  localparam int unsigned FLG_AUTO_AVAIL   = 6;
  localparam int unsigned FLG_MANUAL_AUTH  = 7;
  localparam int unsigned FLG_MANUAL_FIN   = 8;
  localparam int unsigned FLG_AUTO_FIN     = 9;

  typedef enum logic [1:0] {
    OP_STEP     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_SNAPSHOT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_AUTO    = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FANP_UNAVAIL = 2'd0,
    FANP_PENDING = 2'd1,
    FANP_PROVEN  = 2'd2,
    FANP_FAILED  = 2'd3
  } fanp_e;

  typedef enum logic [1:0] {
    AUTH_NONE   = 2'd0,
    AUTH_REMOTE = 2'd1,
    AUTH_AUTO   = 2'd2,
    AUTH_REACQ  = 2'd3
  } auth_e;

  typedef enum logic [1:0] {
    INH_NONE         = 2'd0,
    INH_NO_AUTH      = 2'd1,
    INH_REFRESH      = 2'd2,
    INH_NOT_ELIGIBLE = 2'd3
  } inh_e;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_SENSOR   = 2'd1,
    FAULT_OVERTEMP = 2'd2,
    FAULT_FAN      = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    TSTATE_IDLE     = 2'd0,
    TSTATE_HEATING  = 2'd1,
    TSTATE_COOLDOWN = 2'd2
  } tstate_e;

  typedef enum logic [3:0] {
    RSN_NONE        = 4'd0,
    RSN_OFF         = 4'd1,
    RSN_UNCOMM      = 4'd2,
    RSN_FAULT       = 4'd3,
    RSN_OFFLINE     = 4'd4,
    RSN_NOT_PRINT   = 4'd5,
    RSN_AUTO_POLICY = 4'd6,
    RSN_BAD_TARGET  = 4'd7,
    RSN_FAN_PENDING = 4'd8,
    RSN_BAD_MODE    = 4'd9,
    RSN_NO_AUTH     = 4'd10,
    RSN_REFRESH     = 4'd11,
    RSN_AUTO_AUTH   = 4'd12
  } reason_e;

  // Input item without the operation code; mode sits in the lowest bits.
  typedef struct packed {
    logic signed [TEMP_W-1:0] auto_target;
    logic signed [TEMP_W-1:0] manual_target;
    logic [9:0]               condition_flags;
    logic [1:0]               inhibit_in;
    logic [1:0]               authority_in;
    logic [1:0]               fan_check;
    logic [2:0]               sensor_good;
    logic [1:0]               mode;
  } item_t;

  // Result record; heater_on sits in the lowest bit.
  typedef struct packed {
    reason_e                  stop_cause;
    fault_e                   fault_code;
    tstate_e                  heat_phase;
    logic [1:0]               inhibit_out;
    logic [1:0]               authority_out;
    logic                     thermal_needed;
    logic signed [TEMP_W-1:0] effective_target;
    logic [6:0]               fan_duty;
    logic                     heater_on;
  } rec_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_min;
    logic signed [TEMP_W-1:0] target_max;
  } cfg_t;

  localparam rec_t REC_OFF = '{
    stop_cause:       RSN_OFF,
    fault_code:       FAULT_NONE,
    heat_phase:       TSTATE_IDLE,
    inhibit_out:      2'd0,
    authority_out:    2'd0,
    thermal_needed:   1'b0,
    effective_target: 16'sd0,
    fan_duty:         FAN_STOPPED,
    heater_on:        1'b0
  };

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned REC_W  = $bits(rec_t);

endpackage

`default_nettype wire

### sv/heater_safety_interlock_top.sv
// A beat accepted into the input register is decided from it and lands in the
// result register when that is free or drains, so a stalled output holds it
// back. Throughput: one beat per cycle while m_axis_tready is high; hsi_core
// is combinational and the latched fault and last record update as the beat
// advances. Reset clears the latched fault, restores the off record and the
// default target window; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Heater safety interlock top level
// Stream in, stream out, with an APB-style port for the target window.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_safety_interlock_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: mode, sensor_good, fan_check, authority_in, inhibit_in,
  //        condition_flags, manual_target, auto_target, zero padding
  input  wire logic [hsi_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: operation
  input  wire logic [hsi_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: heater_on, fan_duty, effective_target, thermal_needed,
  //        authority_out, inhibit_out, heat_phase, fault_code,
  //        stop_cause, clear_ok, zero padding
  output logic      [hsi_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hsi_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [hsi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [hsi_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  hsi_pkg::cfg_t   cfg;

  logic            in_valid_q, in_valid_d;
  hsi_pkg::item_t  in_item_q;
  logic [1:0]      in_op_q;
  logic            out_valid_q, out_valid_d;
  hsi_pkg::rec_t   out_rec_q;
  logic            out_ok_q;

  hsi_pkg::fault_e fault_q;
  hsi_pkg::rec_t   last_q;

  hsi_pkg::fault_e fault_d;
  hsi_pkg::rec_t   rec_d;
  logic            clear_ok_d;

  logic            in_take;
  logic            advance;

  hsi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hsi_core u_core (
    .op_i       (in_op_q),
    .item_i     (in_item_q),
    .cfg_i      (cfg),
    .fault_i    (fault_q),
    .rec_i      (last_q),
    .fault_o    (fault_d),
    .rec_o      (rec_d),
    .clear_ok_o (clear_ok_d)
  );

  // The held beat moves on whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fault_q     <= hsi_pkg::FAULT_NONE;
      last_q      <= hsi_pkg::REC_OFF;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        fault_q <= fault_d;
        last_q  <= rec_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= s_axis_tdata[hsi_pkg::ITEM_W-1:0];
      in_op_q   <= s_axis_tuser;
    end
    if (advance) begin
      out_rec_q <= rec_d;
      out_ok_q  <= clear_ok_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(hsi_pkg::M_TDATA_W-hsi_pkg::REC_W-1){1'b0}}, out_ok_q, out_rec_q};

  // Heat is only ever requested with no block reason, no fault and full fan.
  a_heat_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_rec_q.heater_on) |->
      (out_rec_q.stop_cause == hsi_pkg::RSN_NONE
       && out_rec_q.fault_code == hsi_pkg::FAULT_NONE
       && out_rec_q.fan_duty == hsi_pkg::FAN_FULL))
    else $error("heat requested with a block reason, fault or fan off");

  // An accepted clear leaves the fault cleared and the off record in place.
  a_clear_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && clear_ok_d) |=>
      (fault_q == hsi_pkg::FAULT_NONE && last_q == hsi_pkg::REC_OFF
       && out_ok_q && out_rec_q == hsi_pkg::REC_OFF))
    else $error("fault clear did not restore the off record");

  // After each advance the result register mirrors the record the state now holds.
  a_out_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_rec_q == last_q))
    else $error("delivered record differs from the stored record");

  // A fan fault only appears through a step that saw a failed fan proof.
  a_fan_fault_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fault_q != hsi_pkg::FAULT_FAN && fault_d == hsi_pkg::FAULT_FAN) |->
      (in_op_q == hsi_pkg::OP_STEP && in_item_q.fan_check == hsi_pkg::FANP_FAILED))
    else $error("fan fault latched without a failed fan proof");

endmodule

`default_nettype wire

### sv/hsi_cfg.sv
// ----------------------------------------------------------------------------
// Heater safety interlock configuration registers
// APB-style register file holding the manual target window.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hsi_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [hsi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [hsi_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output hsi_pkg::cfg_t                          cfg_o
);

  logic signed [hsi_pkg::TEMP_W-1:0] min_q, min_d;
  logic signed [hsi_pkg::TEMP_W-1:0] max_q, max_d;
  logic                              wr_en;
  logic                              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      unique case (reg_sel)
        hsi_pkg::REG_TARGET_MIN: min_d = pwdata[hsi_pkg::TEMP_W-1:0];
        hsi_pkg::REG_TARGET_MAX: max_d = pwdata[hsi_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= hsi_pkg::TARGET_MIN_RST;
      max_q <= hsi_pkg::TARGET_MAX_RST;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Reads return the register sign-extended to the bus width.
  always_comb begin
    unique case (reg_sel)
      hsi_pkg::REG_TARGET_MIN:
        prdata = {{(hsi_pkg::APB_DATA_W-hsi_pkg::TEMP_W){min_q[hsi_pkg::TEMP_W-1]}}, min_q};
      hsi_pkg::REG_TARGET_MAX:
        prdata = {{(hsi_pkg::APB_DATA_W-hsi_pkg::TEMP_W){max_q[hsi_pkg::TEMP_W-1]}}, max_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.target_min = min_q;
  assign cfg_o.target_max = max_q;

endmodule

`default_nettype wire

### sv/hsi_core.sv
// ----------------------------------------------------------------------------
// Heater safety interlock decision logic
// Priority chain for a step, the fault-clear check and the snapshot select.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_core (
  input  wire logic [1:0]       op_i,
  input  wire hsi_pkg::item_t   item_i,
  input  wire hsi_pkg::cfg_t    cfg_i,
  input  wire hsi_pkg::fault_e  fault_i,
  input  wire hsi_pkg::rec_t    rec_i,
  output hsi_pkg::fault_e       fault_o,
  output hsi_pkg::rec_t         rec_o,
  output logic                  clear_ok_o
);

  logic [9:0]          fl;
  hsi_pkg::fault_e     fault_chk;
  hsi_pkg::fault_e     fault_step;
  hsi_pkg::reason_e    reason;
  hsi_pkg::auth_e      heat_auth;
  logic signed [15:0]  heat_target;
  logic                heat;
  logic                manual_ok;
  logic                auto_ok;
  logic [1:0]          blk_inhibit;
  logic                therm;
  hsi_pkg::rec_t       step_rec;
  logic                clear_pass;

  assign fl = item_i.condition_flags;

  assign manual_ok = fl[hsi_pkg::FLG_MANUAL_FIN]
                   && !($signed(item_i.manual_target) < $signed(cfg_i.target_min))
                   && !($signed(item_i.manual_target) > $signed(cfg_i.target_max));
  assign auto_ok   = fl[hsi_pkg::FLG_AUTO_AVAIL] && fl[hsi_pkg::FLG_AUTO_FIN]
                   && ($signed(item_i.auto_target) > 16'sd0);

  // Sensor and overtemperature faults latch ahead of every later check;
  // overtemperature wins when both are present.
  always_comb begin
    fault_chk = fault_i;
    if (item_i.sensor_good != hsi_pkg::SENSORS_ALL) fault_chk = hsi_pkg::FAULT_SENSOR;
    if (fl[hsi_pkg::FLG_OVERTEMP]) fault_chk = hsi_pkg::FAULT_OVERTEMP;
  end

  always_comb begin
    fault_step  = fault_i;
    reason      = hsi_pkg::RSN_NONE;
    heat        = 1'b0;
    heat_auth   = hsi_pkg::AUTH_NONE;
    heat_target = 16'sd0;
    if (!fl[hsi_pkg::FLG_COMMISSIONED]) begin
      reason = hsi_pkg::RSN_UNCOMM;
    end else begin
      fault_step = fault_chk;
      if (fault_chk != hsi_pkg::FAULT_NONE) begin
        reason = hsi_pkg::RSN_FAULT;
      end else if (item_i.mode == hsi_pkg::MODE_OFF) begin
        reason = hsi_pkg::RSN_OFF;
      end else if (item_i.mode == hsi_pkg::MODE_INVALID) begin
        reason = hsi_pkg::RSN_BAD_MODE;
      end else if (item_i.fan_check == hsi_pkg::FANP_FAILED) begin
        fault_step = hsi_pkg::FAULT_FAN;
        reason     = hsi_pkg::RSN_FAULT;
      end else if (item_i.fan_check != hsi_pkg::FANP_PROVEN) begin
        reason = hsi_pkg::RSN_FAN_PENDING;
      end else if (item_i.mode == hsi_pkg::MODE_AUTO) begin
        if (item_i.authority_in != hsi_pkg::AUTH_AUTO) begin
          reason = hsi_pkg::RSN_AUTO_AUTH;
        end else if (!fl[hsi_pkg::FLG_ONLINE]) begin
          reason = hsi_pkg::RSN_OFFLINE;
        end else if (!fl[hsi_pkg::FLG_PRINTING]) begin
          reason = hsi_pkg::RSN_NOT_PRINT;
        end else if (!auto_ok) begin
          reason = hsi_pkg::RSN_AUTO_POLICY;
        end else begin
          heat        = 1'b1;
          heat_auth   = hsi_pkg::AUTH_AUTO;
          heat_target = item_i.auto_target;
        end
      end else if (item_i.authority_in == hsi_pkg::AUTH_REACQ
                   || item_i.inhibit_in == hsi_pkg::INH_REFRESH) begin
        reason = hsi_pkg::RSN_REFRESH;
      end else if (item_i.authority_in != hsi_pkg::AUTH_REMOTE
                   || !fl[hsi_pkg::FLG_MANUAL_AUTH]) begin
        reason = hsi_pkg::RSN_NO_AUTH;
      end else if (!manual_ok) begin
        reason = hsi_pkg::RSN_BAD_TARGET;
      end else begin
        heat        = 1'b1;
        heat_auth   = hsi_pkg::AUTH_REMOTE;
        heat_target = item_i.manual_target;
      end
    end
  end

  always_comb begin
    case (reason) inside
      hsi_pkg::RSN_NO_AUTH: blk_inhibit = hsi_pkg::INH_NO_AUTH;
      hsi_pkg::RSN_REFRESH: blk_inhibit = hsi_pkg::INH_REFRESH;
      hsi_pkg::RSN_OFFLINE, hsi_pkg::RSN_NOT_PRINT, hsi_pkg::RSN_AUTO_POLICY,
      hsi_pkg::RSN_BAD_TARGET, hsi_pkg::RSN_FAN_PENDING, hsi_pkg::RSN_AUTO_AUTH:
        blk_inhibit = hsi_pkg::INH_NOT_ELIGIBLE;
      default: blk_inhibit = item_i.inhibit_in;
    endcase
  end

  // A blocked step still runs the fan when the chamber needs thermal management.
  assign therm = fl[hsi_pkg::FLG_COOLDOWN] || fl[hsi_pkg::FLG_FAULT_THERM]
              || (fault_step == hsi_pkg::FAULT_FAN) || (reason == hsi_pkg::RSN_FAN_PENDING);

  always_comb begin
    if (heat) begin
      step_rec.stop_cause       = hsi_pkg::RSN_NONE;
      step_rec.fault_code       = hsi_pkg::FAULT_NONE;
      step_rec.heat_phase       = hsi_pkg::TSTATE_HEATING;
      step_rec.inhibit_out      = hsi_pkg::INH_NONE;
      step_rec.authority_out    = heat_auth;
      step_rec.thermal_needed   = 1'b1;
      step_rec.effective_target = heat_target;
      step_rec.fan_duty         = hsi_pkg::FAN_FULL;
      step_rec.heater_on        = 1'b1;
    end else begin
      step_rec.stop_cause       = reason;
      step_rec.fault_code       = fault_step;
      step_rec.heat_phase       = therm ? hsi_pkg::TSTATE_COOLDOWN : hsi_pkg::TSTATE_IDLE;
      step_rec.inhibit_out      = blk_inhibit;
      step_rec.authority_out    = item_i.authority_in;
      step_rec.thermal_needed   = therm;
      step_rec.effective_target = 16'sd0;
      step_rec.fan_duty         = therm ? hsi_pkg::FAN_FULL : hsi_pkg::FAN_STOPPED;
      step_rec.heater_on        = 1'b0;
    end
  end

  // A clear needs the mode off, every sensor good and no overtemperature,
  // cooldown or thermal-fault flag.
  assign clear_pass = (item_i.mode == hsi_pkg::MODE_OFF)
                   && (item_i.sensor_good == hsi_pkg::SENSORS_ALL)
                   && !fl[hsi_pkg::FLG_OVERTEMP] && !fl[hsi_pkg::FLG_COOLDOWN]
                   && !fl[hsi_pkg::FLG_FAULT_THERM];

  always_comb begin
    fault_o    = fault_i;
    rec_o      = rec_i;
    clear_ok_o = 1'b0;
    case (op_i)
      hsi_pkg::OP_STEP: begin
        fault_o = fault_step;
        rec_o   = step_rec;
      end
      hsi_pkg::OP_CLEAR: begin
        if (clear_pass) begin
          fault_o    = hsi_pkg::FAULT_NONE;
          rec_o      = hsi_pkg::REC_OFF;
          clear_ok_o = 1'b1;
        end
      end
      default: ; // snapshot, and the unused code behaves the same
    endcase
  end

endmodule

`default_nettype wire
